// ===== hdl/mnsp_pkg.sv =====
`default_nettype none

package mnsp_pkg;

    localparam int NOTE_W  = 7;
    localparam int PULSE_W = 32;

    typedef struct packed {
        logic               first_of_track;
        logic               is_note_on;
        logic [NOTE_W-1:0]  note_number;
        logic [NOTE_W-1:0]  velocity;
        logic [PULSE_W-1:0] event_pulse;
    } event_t;

    typedef struct packed {
        logic [NOTE_W-1:0]  span_note;
        logic [PULSE_W-1:0] span_start;
        logic [PULSE_W-1:0] span_end;
    } span_t;

    // table lookup outcome handed to the output stage
    typedef struct packed {
        logic               hit;
        logic [NOTE_W-1:0]  note;
        logic [PULSE_W-1:0] end_pulse;
    } lookup_t;

endpackage

`default_nettype wire

// ===== hdl/mnsp_note_table.sv =====
`default_nettype none

module mnsp_note_table #(
    parameter int NOTE_COUNT = 128,
    parameter int PULSE_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire mnsp_pkg::event_t                 req,
    output mnsp_pkg::lookup_t                     lookup,
    output logic [mnsp_pkg::PULSE_W-1:0]          start_pulse
);

    localparam int IDX_W = $clog2(NOTE_COUNT);
    // wide enough for both the note field and the table size
    localparam int CMP_W = ((IDX_W > mnsp_pkg::NOTE_W) ? IDX_W : mnsp_pkg::NOTE_W) + 1;

    logic [NOTE_COUNT-1:0] active_reg;
    logic [NOTE_COUNT-1:0] active_next;
    logic [PULSE_BITS-1:0] pulse_mem [NOTE_COUNT];
    logic [PULSE_BITS-1:0] rd_data_reg;

    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic                  real_on;
    logic [PULSE_BITS-1:0] pulse;

    assign in_range = CMP_W'(req.note_number) < CMP_W'(NOTE_COUNT);
    assign idx      = IDX_W'(req.note_number);
    assign real_on  = req.is_note_on && (req.velocity != '0);
    assign pulse    = PULSE_BITS'(req.event_pulse);

    always_comb
    begin
        active_next = active_reg;
        if (req.first_of_track)
        begin
            active_next = '0;
        end
        // an active note always closes; a real note-on reopens it
        if (in_range)
        begin
            active_next[idx] = real_on;
        end
    end

    assign lookup.hit       = in_range && !req.first_of_track && active_reg[idx];
    assign lookup.note      = req.note_number;
    assign lookup.end_pulse = mnsp_pkg::PULSE_W'(pulse);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
        end
    end

    // read before write: the read returns the start of the span being closed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= pulse_mem[idx];
            if (in_range && real_on)
            begin
                pulse_mem[idx] <= pulse;
            end
        end
    end

    assign start_pulse = mnsp_pkg::PULSE_W'(rd_data_reg);

endmodule

`default_nettype wire

// ===== hdl/mnsp_out_stage.sv =====
`default_nettype none

module mnsp_out_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire mnsp_pkg::lookup_t           lookup,
    input  wire logic [mnsp_pkg::PULSE_W-1:0] start_pulse,
    output logic                             busy,
    output logic                             span_valid,
    input  wire logic                        span_stall,
    output mnsp_pkg::span_t                  span_data
);

    logic                             hold_valid_reg;
    logic [mnsp_pkg::NOTE_W-1:0]      hold_note_reg;
    logic [mnsp_pkg::PULSE_W-1:0]     hold_end_reg;
    logic                             out_valid_reg;
    mnsp_pkg::span_t                  out_reg;
    logic                             out_free;
    logic                             hold_move;

    assign out_free  = !out_valid_reg || !span_stall;
    assign hold_move = hold_valid_reg && out_free;
    assign busy      = hold_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hold_valid_reg <= lookup.hit;
            end
            else if (hold_move)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_note_reg <= lookup.note;
            hold_end_reg  <= lookup.end_pulse;
        end
        if (hold_move)
        begin
            out_reg.span_note  <= hold_note_reg;
            out_reg.span_start <= start_pulse;
            out_reg.span_end   <= hold_end_reg;
        end
    end

    assign span_valid = out_valid_reg;
    assign span_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/midi_note_span_pairing.sv =====
// Pipeline: a closing request fills the hold stage, then the output register
// once that is free. Throughput: one request per cycle while not busy; the
// note table lookup and update complete at the accepting edge, and a hold
// stage plus the output register let one more request in while a span stalls.
// Reset: rst_n clears all active flags and the pipeline valids at once;
// start pulses are not reset.
`default_nettype none

module midi_note_span_pairing #(
    parameter int NOTE_COUNT = 128,
    parameter int PULSE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              event_valid,
    output logic                   event_stall,
    input  wire mnsp_pkg::event_t  event_data,
    output logic                   span_valid,
    input  wire logic              span_stall,
    output mnsp_pkg::span_t        span_data
);

    logic                          accept;
    logic                          busy;
    mnsp_pkg::lookup_t             lookup;
    logic [mnsp_pkg::PULSE_W-1:0]  start_pulse;

    assign event_stall = busy;
    assign accept      = event_valid && !busy;

    mnsp_note_table #(
        .NOTE_COUNT (NOTE_COUNT),
        .PULSE_BITS (PULSE_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (event_data),
        .lookup      (lookup),
        .start_pulse (start_pulse)
    );

    mnsp_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .lookup      (lookup),
        .start_pulse (start_pulse),
        .busy        (busy),
        .span_valid  (span_valid),
        .span_stall  (span_stall),
        .span_data   (span_data)
    );

endmodule

`default_nettype wire

// ===== hdl/mnsp_checker.sv =====
`default_nettype none

module mnsp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             event_valid,
    input wire logic             event_stall,
    input wire mnsp_pkg::event_t event_data,
    input wire logic             span_valid,
    input wire logic             span_stall,
    input wire mnsp_pkg::span_t  span_data
);

    // a pending span holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && span_stall |=> span_valid)
    else $error("span request dropped while stalled");

    // requests back up only behind a stalled span
    assert property (@(posedge clk) disable iff (!rst_n)
        event_stall |-> span_valid && span_stall)
    else $error("request stalled with output free");

    assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && span_stall |=> $stable(span_data))
    else $error("span payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid && $stable(event_data))
    else $error("note event request changed while stalled");

    assert property (@(posedge clk)
        !rst_n && $past(!rst_n) |-> !span_valid && !event_stall)
    else $error("outputs active during reset");

endmodule

bind midi_note_span_pairing mnsp_checker u_mnsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_data  (event_data),
    .span_valid  (span_valid),
    .span_stall  (span_stall),
    .span_data   (span_data)
);

`default_nettype wire
